// File: src/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and sorting-network functions of the 3x3 median
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

  // Pixel and channel formats.
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumCh  = 3;
  localparam int unsigned PixW   = ChanW * NumCh;

  // Frame geometry limits and counter widths.
  localparam int unsigned MinSize   = 3;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned RowW      = 12;
  localparam int unsigned SizeW     = 13;
  localparam int unsigned WidthRegW = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned CfgDataW  = 13;

  // Register reset values.
  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd480;

  // Configuration register indexes.
  localparam logic CfgImageWidth  = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  typedef logic [PixW-1:0]          pixel_t;
  typedef logic [8:0][PixW-1:0]     mf3_win_t;
  typedef logic [8:0][ChanW-1:0]    mf3_byte9_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } mf3_marks_t;

  // Compare-exchange: the smaller value ends up at position a.
  function automatic mf3_byte9_t cswap(mf3_byte9_t p, int unsigned a, int unsigned b);
    mf3_byte9_t v;
    v = p;
    if (p[a] > p[b]) begin
      v[a] = p[b];
      v[b] = p[a];
    end
    return v;
  endfunction

  // First half of the nine-input median network: sorts each triple.
  function automatic mf3_byte9_t med_part_a(mf3_byte9_t p);
    mf3_byte9_t v;
    v = p;
    v = cswap(v, 1, 2); v = cswap(v, 4, 5); v = cswap(v, 7, 8);
    v = cswap(v, 0, 1); v = cswap(v, 3, 4); v = cswap(v, 6, 7);
    v = cswap(v, 1, 2); v = cswap(v, 4, 5); v = cswap(v, 7, 8);
    return v;
  endfunction

  // Second half: combines the sorted triples and picks the middle value.
  function automatic logic [ChanW-1:0] med_part_b(mf3_byte9_t p);
    mf3_byte9_t v;
    v = p;
    v = cswap(v, 0, 3); v = cswap(v, 5, 8); v = cswap(v, 4, 7);
    v = cswap(v, 3, 6); v = cswap(v, 1, 4); v = cswap(v, 2, 5);
    v = cswap(v, 4, 7); v = cswap(v, 4, 2); v = cswap(v, 6, 4);
    v = cswap(v, 4, 2);
    return v[4];
  endfunction

endpackage

`default_nettype wire

// File: src/mf3_line_store.sv
// ----------------------------------------------------------------------------
// mf3_line_store
// Combined storage of the two previous image rows, one entry per column.
// Upper row in the high half, lower row in the low half; registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 48
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: src/mf3_median_pipe.sv
// ----------------------------------------------------------------------------
// mf3_median_pipe
// Two-stage per-channel median-of-nine network with an output register.
// Each stage holds its item until the next stage can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mf3_pkg::mf3_win_t  win_i,
  input  wire mf3_pkg::mf3_marks_t marks_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mf3_pkg::pixel_t         med_o,
  output mf3_pkg::mf3_marks_t     marks_o
);

  import mf3_pkg::*;

  mf3_byte9_t    part_d [NumCh];
  mf3_byte9_t    part_q [NumCh];
  mf3_marks_t    s2_marks_q;
  logic          s2_valid_q;
  pixel_t        med_d;
  pixel_t        med_q;
  mf3_marks_t    out_marks_q;
  logic          out_valid_q;
  logic          out_free;
  logic          s2_fire;
  logic          s2_ready;

  // Split the window into channels and run the first half of the network.
  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      mf3_byte9_t bytes;
      for (int k = 0; k < 9; k++) begin
        bytes[k] = win_i[k][ch*ChanW +: ChanW];
      end
      part_d[ch] = med_part_a(bytes);
    end
  end

  // Second half of the network on the registered partial sort.
  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      med_d[ch*ChanW +: ChanW] = med_part_b(part_q[ch]);
    end
  end

  // Stage handshakes.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_fire    = s2_valid_q && out_free;
  assign s2_ready   = !s2_valid_q || out_free;
  assign in_ready_o = s2_ready;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s2_ready) begin
      part_q     <= part_d;
      s2_marks_q <= marks_i;
    end
    if (s2_fire) begin
      med_q       <= med_d;
      out_marks_q <= s2_marks_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign med_o       = med_q;
  assign marks_o     = out_marks_q;

endmodule

`default_nettype wire

// File: src/median_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// Streaming 3x3 median filter on three-channel 8-bit pixels in raster order.
// ----------------------------------------------------------------------------
// Pipeline: the pixel that completes its window is registered in stage one along
//   with its line store read, the first sorting half fills the partial sort
//   register, and the second sorting half feeds the output register.
// Throughput: one pixel per cycle unless out_ready_i holds the output; the line
//   store has one read and one write port, and each pixel uses each once.
// Reset: clears the column and row counters, the window, all valid flags and
//   sets the size to 640x480; the line store keeps its contents.
`default_nettype none

module median_filter_3x3_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration writes.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  // Pixel input.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  pixel_ch0_i,
  input  wire logic [7:0]  pixel_ch1_i,
  input  wire logic [7:0]  pixel_ch2_i,
  // Result output.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       median_ch0_o,
  output logic [7:0]       median_ch1_o,
  output logic [7:0]       median_ch2_o,
  output logic             row_end_o,
  output logic             frame_end_o
);

  import mf3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;

  // Position counters.
  logic [CW-1:0]   col_q;
  logic [RowW-1:0] row_q;

  // Stage one: waits for the line store read.
  logic            s1_valid_q;
  logic            s1_emit_q;
  pixel_t          s1_pix_q;
  logic [CW-1:0]   s1_addr_q;
  mf3_marks_t      s1_marks_q;

  // Columns c-2 and c-1 of the window.
  pixel_t          win_q [6];

  logic [SizeW-1:0] width_ext;
  logic [SizeW-1:0] w_use;
  logic [SizeW-1:0] w_last;
  logic [SizeW-1:0] h_use;
  logic [SizeW-1:0] h_last;
  logic             col_last;
  logic             row_last;
  logic             emit;
  logic             in_fire;
  logic             s1_fire;
  logic             s1_ready;
  logic             med_ready;
  logic [2*PixW-1:0] rd_data;
  pixel_t           top;
  pixel_t           mid;
  mf3_win_t         win_full;
  mf3_marks_t       marks;
  mf3_marks_t       out_marks;
  pixel_t           med;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgImageWidth:  width_q  <= cfg_data_i[WidthRegW-1:0];
        CfgImageHeight: height_q <= cfg_data_i[HeightRegW-1:0];
        default:        ;
      endcase
    end
  end

  // Size in use, clamped to the supported range.
  assign width_ext = SizeW'(width_q);

  always_comb begin
    if (width_ext < SizeW'(MinSize)) begin
      w_use = SizeW'(MinSize);
    end else if (width_ext > SizeW'(MAX_WIDTH)) begin
      w_use = SizeW'(MAX_WIDTH);
    end else begin
      w_use = width_ext;
    end
    if (height_q < SizeW'(MinSize)) begin
      h_use = SizeW'(MinSize);
    end else if (height_q > SizeW'(MaxHeight)) begin
      h_use = SizeW'(MaxHeight);
    end else begin
      h_use = height_q;
    end
  end

  assign w_last   = w_use - SizeW'(1);
  assign h_last   = h_use - SizeW'(1);
  // A counter past the last position after a size change counts as the last one.
  assign col_last = SizeW'(col_q) >= w_last;
  assign row_last = SizeW'(row_q) >= h_last;
  assign emit     = (row_q >= RowW'(2)) && (col_q >= CW'(2));

  // Pipeline handshakes.
  assign s1_fire    = s1_valid_q && (!s1_emit_q || med_ready);
  assign s1_ready   = !s1_valid_q || s1_fire;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  // Column and row counters advance on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Stage one valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q             <= {pixel_ch2_i, pixel_ch1_i, pixel_ch0_i};
      s1_addr_q            <= col_q;
      s1_emit_q            <= emit;
      s1_marks_q.row_end   <= col_last;
      s1_marks_q.frame_end <= col_last && row_last;
    end
  end

  // Line stores. Consecutive pixels always address different columns, so the
  // write-back of one pixel never meets the read of the next at one entry.
  mf3_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (2*PixW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({mid, s1_pix_q})
  );

  assign top = rd_data[2*PixW-1:PixW];
  assign mid = rd_data[PixW-1:0];

  // Full window: two stored columns plus the column just read.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_full[k] = win_q[k];
    end
    win_full[6] = top;
    win_full[7] = mid;
    win_full[8] = s1_pix_q;
  end

  // Window shift on each pixel leaving stage one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_fire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= s1_pix_q;
    end
  end

  assign marks = s1_marks_q;

  // Median network and output register; only interior pixels enter.
  mf3_median_pipe u_median_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q && s1_emit_q),
    .in_ready_o  (med_ready),
    .win_i       (win_full),
    .marks_i     (marks),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .med_o       (med),
    .marks_o     (out_marks)
  );

  assign median_ch0_o = med[7:0];
  assign median_ch1_o = med[15:8];
  assign median_ch2_o = med[23:16];
  assign row_end_o    = out_marks.row_end;
  assign frame_end_o  = out_marks.frame_end;

endmodule

`default_nettype wire
